[rtl/core/mep_pkg.sv]
package mep_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_W    = 32;
    localparam int STEP_W     = 31;
    localparam int Z_W        = 40;
    localparam int COUNT_W    = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_EDGE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP    = 2'd3;

    localparam logic signed [COORD_W-1:0] LEFT_EDGE_RST   = -32'sd64290292;
    localparam logic signed [COORD_W-1:0] TOP_EDGE_RST    = 32'sd177167401;
    localparam logic [STEP_W-1:0]         COLUMN_STEP_RST = 31'd3146;
    localparam logic [STEP_W-1:0]         ROW_STEP_RST    = 31'd3146;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COUNT_W-1:0] escape_count;
    } t_pixel_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_re;
        logic signed [COORD_W-1:0] c_im;
    } t_point;

endpackage

[rtl/core/mep_front.sv]
// maps pixel to c; step*index product registered before the saturating add
module mep_front import mep_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  t_pixel_in                 i_pixel,
    input  logic signed [COORD_W-1:0] i_left_edge,
    input  logic signed [COORD_W-1:0] i_top_edge,
    input  logic [STEP_W-1:0]         i_column_step,
    input  logic [STEP_W-1:0]         i_row_step,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_point                    o_point
);
    logic              r_s1_valid, r_s2_valid;
    logic [STEP_W+9:0] r_re_prod, r_im_prod;
    t_point            r_point;
    logic signed [STEP_W+12:0] re_sum, im_sum;
    logic              s2_free, s1_free;

    assign s2_free = !r_s2_valid || i_ready;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_full  = !s1_free;

    assign re_sum = $signed({{12{i_left_edge[COORD_W-1]}}, i_left_edge})
                  + $signed({2'b00, r_re_prod});
    assign im_sum = $signed({{12{i_top_edge[COORD_W-1]}}, i_top_edge})
                  - $signed({2'b00, r_im_prod});

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [STEP_W+12:0] v);
        if (v > $signed({{12{1'b0}}, 1'b0, {(COORD_W-1){1'b1}}}))
            return {1'b0, {(COORD_W-1){1'b1}}};
        else if (v < $signed({{12{1'b1}}, 1'b1, {(COORD_W-1){1'b0}}}))
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return v[COORD_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) r_s1_valid <= i_push;
            if (s2_free) r_s2_valid <= r_s1_valid;
        end
        if (s1_free && i_push) begin
            r_re_prod <= i_column_step * i_pixel.col;
            r_im_prod <= i_row_step * i_pixel.row;
        end
        if (s2_free && r_s1_valid) begin
            r_point.c_re <= sat(re_sum);
            r_point.c_im <= sat(im_sum);
        end
    end

    assign o_valid = r_s2_valid;
    assign o_point = r_point;
endmodule

[rtl/core/mep_queue.sv]
module mep_queue import mep_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_point i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_point o_data
);
    t_point     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

[rtl/core/mep_iter.sv]
// one z iteration per S_MUL and S_ADD pass: squares registered, then add and escape test
module mep_iter import mep_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_point     i_point,
    output logic       o_empty,
    input  logic       i_pop,
    output t_pixel_out o_pixel
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_COLOR} t_state;

    localparam logic [COUNT_W-1:0] LIMIT = 13'd4096;
    // |z| stays below about 12, so 34 signed bits carry the multiplier operands
    localparam int M_W = 34;
    localparam int P_W = 2 * M_W;

    t_state                  r_state;
    logic signed [Z_W-1:0]   r_zre, r_zim;
    t_point                  r_c;
    logic [COUNT_W-1:0]      r_n;
    logic signed [Z_W-1:0]   r_x2, r_y2, r_xy;
    logic                    r_out_valid;
    t_pixel_out              r_out;
    logic [COUNT_W-1:0]      r_cnt_hold;

    function automatic logic signed [Z_W-1:0] qfloor(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] s;
        s = p >>> FRAC_BITS;
        return s[Z_W-1:0];
    endfunction

    logic signed [M_W-1:0] zre_m, zim_m;
    logic signed [P_W-1:0] px2, py2, pxy;
    logic signed [Z_W+1:0] mag;
    logic signed [Z_W+1:0] bound;
    assign zre_m = r_zre[M_W-1:0];
    assign zim_m = r_zim[M_W-1:0];
    assign px2   = zre_m * zre_m;
    assign py2   = zim_m * zim_m;
    assign pxy   = (zre_m <<< 1) * zim_m;
    assign mag   = {{2{r_x2[Z_W-1]}}, r_x2} + {{2{r_y2[Z_W-1]}}, r_y2};
    assign bound = (Z_W+2)'(4) <<< FRAC_BITS;

    // colour mapping; the divisions by 126, 127, 255, 511, 1023 and 2047 are
    // reciprocal multiplies scaled by 2^28, exact over each segment's offsets
    logic [7:0]  red, green;
    logic [12:0] n;
    logic [10:0] c_off;
    logic [28:0] c_recip;
    logic [7:0]  c_base;
    logic [39:0] c_prod;
    logic [7:0]  c_val;
    assign n      = r_cnt_hold;
    assign c_prod = 40'(c_off) * 40'(c_recip);
    assign c_val  = c_prod[35:28] + c_base;

    always_comb begin
        c_off   = '0;
        c_recip = '0;
        c_base  = '0;
        if (n < 13'd128) begin
            c_off   = 11'(n[5:0]);
            c_recip = 29'd272760832;
            c_base  = 8'd128;
        end else if (n < 13'd256) begin
            c_off   = 11'(n[6:0]);
            c_recip = 29'd131055104;
            c_base  = 8'd193;
        end else if (n < 13'd512) begin
            c_off   = 11'(n[7:0]);
            c_recip = 29'd65269632;
            c_base  = 8'd1;
        end else if (n < 13'd1024) begin
            c_off   = 11'(n[8:0]);
            c_recip = 29'd33095664;
            c_base  = 8'd64;
        end else if (n < 13'd2048) begin
            c_off   = 11'(n[9:0]);
            c_recip = 29'd16531452;
            c_base  = 8'd128;
        end else begin
            c_off   = n[10:0];
            c_recip = 29'd8261631;
            c_base  = 8'd192;
        end
    end

    always_comb begin
        red = 8'd0;
        green = 8'd0;
        if (n >= LIMIT) begin
            red = 8'd0;
        end else if (n < 13'd64) begin
            red = {n[6:0], 1'b0};
        end else if (n < 13'd256) begin
            red = c_val;
        end else begin
            red = 8'd255;
            green = c_val;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_empty = !r_out_valid;
    assign o_pixel = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_COLOR && (!r_out_valid || i_pop)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_c     <= i_point;
                        r_zre   <= '0;
                        r_zim   <= '0;
                        r_n     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_x2    <= qfloor(px2);
                    r_y2    <= qfloor(py2);
                    r_xy    <= qfloor(pxy);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (mag > bound || r_n == LIMIT) begin
                        r_cnt_hold <= r_n;
                        r_state    <= S_COLOR;
                    end else begin
                        r_zre   <= r_x2 - r_y2 + Z_W'(r_c.c_re);
                        r_zim   <= r_xy + Z_W'(r_c.c_im);
                        r_n     <= r_n + 1'b1;
                        r_state <= (r_n + 1'b1 == LIMIT) ? S_ADD : S_MUL;
                    end
                end
                S_COLOR: begin
                    if (!r_out_valid || i_pop) begin
                        r_out.red          <= red;
                        r_out.green        <= green;
                        r_out.blue         <= 8'd0;
                        r_out.escape_count <= r_cnt_hold;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/core/mandelbrot_escape_pixel.sv]
// path: the front part's registers and the queue feed the back part, which
// takes S_MUL then S_ADD per iteration, then S_COLOR; 4096 iterations at most
// throughput: one item at a time through the shared iteration multipliers;
// front part and a 2-entry queue accept ahead
// reset: synchronous active-low; clears queues and restores config defaults
module mandelbrot_escape_pixel import mep_pkg::*; #(
    parameter int IMAGE_SIZE = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_pixel_in            i_pixel,
    output logic                 empty,
    input  logic                 pop,
    output t_pixel_out           o_pixel,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data
);
    logic signed [COORD_W-1:0] r_left_edge, r_top_edge;
    logic [STEP_W-1:0]         r_column_step, r_row_step;
    logic   f_valid, f_ready, q_valid, q_ready;
    t_point f_point, q_point;
    logic   unused_size;
    assign unused_size = (IMAGE_SIZE > 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_edge   <= LEFT_EDGE_RST;
            r_top_edge    <= TOP_EDGE_RST;
            r_column_step <= COLUMN_STEP_RST;
            r_row_step    <= ROW_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEFT_EDGE:   r_left_edge   <= i_cfg_data;
                CFG_TOP_EDGE:    r_top_edge    <= i_cfg_data;
                CFG_COLUMN_STEP: r_column_step <= i_cfg_data[STEP_W-1:0];
                CFG_ROW_STEP:    r_row_step    <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    mep_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_pixel,
        .i_left_edge(r_left_edge), .i_top_edge(r_top_edge),
        .i_column_step(r_column_step), .i_row_step(r_row_step),
        .o_valid(f_valid), .i_ready(f_ready), .o_point(f_point)
    );

    mep_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_point),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_point)
    );

    mep_iter u_iter (
        .i_clk, .i_rst_n, .i_valid(q_valid && unused_size), .o_ready(q_ready),
        .i_point(q_point), .o_empty(empty), .i_pop(pop), .o_pixel
    );
endmodule
